[hw/rtl/gker_pkg.sv]
// ----------------------------------------------------------------------------
// gker_pkg
// Shared types and constants for the gamepad key edge and auto-repeat block.
// ----------------------------------------------------------------------------
package gker_pkg;

  localparam int KEY_W   = 24;
  localparam int STICK_W = 8;
  localparam int CNT_W   = 32;
  localparam int IVL_W   = 16;
  localparam int THR_W   = 8;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // Fixed button positions.
  localparam logic [KEY_W-1:0] KEY_UP    = KEY_W'(24'h000010);
  localparam logic [KEY_W-1:0] KEY_RIGHT = KEY_W'(24'h000020);
  localparam logic [KEY_W-1:0] KEY_DOWN  = KEY_W'(24'h000040);
  localparam logic [KEY_W-1:0] KEY_LEFT  = KEY_W'(24'h000080);
  localparam logic [KEY_W-1:0] KEY_HOLD  = KEY_W'(24'h020000);

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_HOLD_ZEROES = 3'd0;
  localparam logic [2:0] REG_THRESHOLD   = 3'd1;
  localparam logic [2:0] REG_INTERVAL    = 3'd2;
  localparam logic [2:0] REG_DELAY       = 3'd3;
  localparam logic [2:0] REG_MASK        = 3'd4;

  typedef struct packed {
    logic [KEY_W-1:0]   buttons_in;
    logic               home_down;
    logic [STICK_W-1:0] stick_x_raw;
    logic [STICK_W-1:0] stick_y_raw;
  } in_t;

  typedef struct packed {
    logic [KEY_W-1:0]          held_keys;
    logic [KEY_W-1:0]          pressed_keys;
    logic [KEY_W-1:0]          released_keys;
    logic signed [STICK_W-1:0] stick_x;
    logic signed [STICK_W-1:0] stick_y;
  } out_t;

  typedef struct packed {
    logic               hold_zeroes_stick;
    logic [THR_W-1:0]   dpad_threshold;
    logic [IVL_W-1:0]   repeat_interval;
    logic [IVL_W-1:0]   repeat_delay;
    logic [KEY_W-1:0]   repeat_mask;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_in;
    logic calc;
    logic check;
    logic div_start;
    logic commit;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_mod;
    logic div_busy;
    logic out_free;
  } sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

[hw/rtl/gker_rem.sv]
// ----------------------------------------------------------------------------
// gker_rem
// Iterative remainder unit: restoring division, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module gker_rem
  import gker_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CNT_W-1:0] dividend,
  input  logic [IVL_W-1:0] divisor,
  output logic             busy,
  output logic [IVL_W-1:0] rem
);

  localparam int STEP_W = $clog2(CNT_W);

  logic [CNT_W-1:0]  dvd;
  logic [IVL_W-1:0]  dsr;
  logic [STEP_W-1:0] step;
  logic [IVL_W:0]    rem_sh;
  logic [IVL_W:0]    rem_sub;

  always_comb begin
    rem_sh  = {rem, dvd[CNT_W-1]};
    rem_sub = rem_sh - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= STEP_W'(CNT_W - 1);
    end else if (busy) begin
      if (step == '0) begin
        busy <= 1'b0;
      end else begin
        step <= step - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[CNT_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, dsr}) begin
        rem <= rem_sub[IVL_W-1:0];
      end else begin
        rem <= rem_sh[IVL_W-1:0];
      end
    end
  end

endmodule

[hw/rtl/gker_dp.sv]
// ----------------------------------------------------------------------------
// gker_dp
// Datapath: stick centering, direction merge, repeat counter, edge words,
// kept state and the output register.
// ----------------------------------------------------------------------------
module gker_dp
  import gker_pkg::*;
#(
  parameter int BUTTON_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  output sts_t sts,
  input  cfg_t cfg,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam logic [KEY_W-1:0] BTN_MASK = (BUTTON_BITS >= KEY_W) ? {KEY_W{1'b1}} :
      KEY_W'((64'(1) << BUTTON_BITS) - 64'(1));

  // Captured request and working registers.
  in_t                in_r;
  logic [KEY_W-1:0]   btn_w;
  logic [STICK_W-1:0] sx_w;
  logic [STICK_W-1:0] sy_w;
  logic [CNT_W-1:0]   cnt_w;
  logic               mod_w;

  // Persistent state.
  logic [KEY_W-1:0]   last_held;
  logic [CNT_W-1:0]   repeat_count;
  logic [STICK_W-1:0] stick_x_kept;
  logic [STICK_W-1:0] stick_y_kept;
  logic [KEY_W-1:0]   held_kept;

  logic [KEY_W-1:0]   btn_raw;
  logic [KEY_W-1:0]   btn_dir;
  logic [STICK_W-1:0] sx_c;
  logic [STICK_W-1:0] sy_c;
  logic signed [STICK_W+1:0] sx_e;
  logic signed [STICK_W+1:0] sy_e;
  logic signed [STICK_W+1:0] thr_p;
  logic signed [STICK_W+1:0] thr_n;
  logic [CNT_W-1:0]   cnt_calc;
  logic               need_mod;
  logic               div_busy;
  logic [IVL_W-1:0]   div_rem;
  logic               fire;
  logic [KEY_W-1:0]   prev_eff;
  logic               out_free;

  gker_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (cnt_w - CNT_W'(cfg.repeat_delay)),
    .divisor  (cfg.repeat_interval),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  // Stick and direction merge, evaluated from the captured request.
  always_comb begin
    btn_raw = in_r.buttons_in & BTN_MASK;
    if (cfg.hold_zeroes_stick && ((btn_raw & KEY_HOLD) != '0)) begin
      sx_c = '0;
      sy_c = '0;
    end else begin
      // Subtracting the center of 128 only flips the top bit.
      sx_c = {~in_r.stick_x_raw[STICK_W-1], in_r.stick_x_raw[STICK_W-2:0]};
      sy_c = {~in_r.stick_y_raw[STICK_W-1], in_r.stick_y_raw[STICK_W-2:0]};
    end
    sx_e  = (STICK_W+2)'(signed'(sx_c));
    sy_e  = (STICK_W+2)'(signed'(sy_c));
    thr_p = signed'({2'b00, cfg.dpad_threshold});
    thr_n = -thr_p;
    btn_dir = btn_raw;
    if (cfg.dpad_threshold != '0) begin
      if (sy_e >= thr_p) btn_dir = btn_dir | KEY_DOWN;
      if (sy_e <= thr_n) btn_dir = btn_dir | KEY_UP;
      if (sx_e >= thr_p) btn_dir = btn_dir | KEY_RIGHT;
      if (sx_e <= thr_n) btn_dir = btn_dir | KEY_LEFT;
      btn_dir = btn_dir & BTN_MASK;
    end
    cnt_calc = (last_held == btn_dir) ? repeat_count + 1'b1 : '0;
  end

  // A repeat is possible only for an unchanged state at or past the delay.
  always_comb begin
    need_mod = !in_r.home_down && (cfg.repeat_interval != '0) &&
               (last_held == btn_w) && (cnt_w >= CNT_W'(cfg.repeat_delay));
    fire     = mod_w && (div_rem == '0);
    prev_eff = fire ? (last_held & ~cfg.repeat_mask) : last_held;
    out_free = !out_valid || !out_stall;
    sts.need_mod = need_mod;
    sts.div_busy = div_busy;
    sts.out_free = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.calc) begin
      btn_w <= btn_dir;
      sx_w  <= sx_c;
      sy_w  <= sy_c;
      cnt_w <= cnt_calc;
    end
    if (cmd.check) begin
      mod_w <= need_mod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_held    <= '0;
      repeat_count <= '0;
      stick_x_kept <= '0;
      stick_y_kept <= '0;
      held_kept    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (in_r.home_down) begin
          last_held <= '0;
          held_kept <= '0;
        end else begin
          last_held    <= btn_w;
          held_kept    <= btn_w;
          stick_x_kept <= sx_w;
          stick_y_kept <= sy_w;
          if (cfg.repeat_interval != '0) begin
            repeat_count <= cnt_w;
          end
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (in_r.home_down) begin
        out_data.held_keys     <= '0;
        out_data.pressed_keys  <= '0;
        out_data.released_keys <= '0;
        out_data.stick_x       <= signed'(stick_x_kept);
        out_data.stick_y       <= signed'(stick_y_kept);
      end else begin
        out_data.held_keys     <= btn_w;
        out_data.pressed_keys  <= ~prev_eff & btn_w;
        out_data.released_keys <= prev_eff & ~btn_w;
        out_data.stick_x       <= signed'(sx_w);
        out_data.stick_y       <= signed'(sy_w);
      end
    end
  end

endmodule

[hw/rtl/gker_ctrl.sv]
// ----------------------------------------------------------------------------
// gker_ctrl
// Controller: sequences capture, evaluation, repeat check and result commit.
// ----------------------------------------------------------------------------
module gker_ctrl
  import gker_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        if (sts.need_mod) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIV: begin
        if (!sts.div_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/gamepad_key_edge_repeat.sv]
// An accepted request goes through CALC, CHECK and DONE, with DIV after CHECK
// when the repeat check runs in the 32-step remainder unit; DONE commits the
// result once the output is free. A new request is taken only in IDLE, after
// the last one is committed. The output register lets a new request in while a
// result waits. Reset (rst, synchronous) clears the configuration, controller
// state, key state and out_valid, but not the working registers or out_data.
// ----------------------------------------------------------------------------
// gamepad_key_edge_repeat
// Gamepad button edge detector with stick-to-direction merge and auto-repeat.
// ----------------------------------------------------------------------------
module gamepad_key_edge_repeat
  import gker_pkg::*;
#(
  parameter int BUTTON_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg;
  cmd_t       cmd;
  sts_t       sts;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HOLD_ZEROES: cfg.hold_zeroes_stick <= pwdata[0];
        REG_THRESHOLD:   cfg.dpad_threshold    <= pwdata[THR_W-1:0];
        REG_INTERVAL:    cfg.repeat_interval   <= pwdata[IVL_W-1:0];
        REG_DELAY:       cfg.repeat_delay      <= pwdata[IVL_W-1:0];
        REG_MASK:        cfg.repeat_mask       <= pwdata[KEY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HOLD_ZEROES: prdata = DATA_W'(cfg.hold_zeroes_stick);
      REG_THRESHOLD:   prdata = DATA_W'(cfg.dpad_threshold);
      REG_INTERVAL:    prdata = DATA_W'(cfg.repeat_interval);
      REG_DELAY:       prdata = DATA_W'(cfg.repeat_delay);
      REG_MASK:        prdata = DATA_W'(cfg.repeat_mask);
      default:         prdata = '0;
    endcase
  end

  gker_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gker_dp #(
    .BUTTON_BITS (BUTTON_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg       (cfg),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // Only one request is in flight: an accepted request closes the input.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in flight");

  // A pressed key is always a held key.
  a_pressed_held: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.pressed_keys & ~out_data.held_keys) == '0))
    else $error("pressed key not held");

  // A released key is never a held key.
  a_released_up: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.released_keys & out_data.held_keys) == '0))
    else $error("released key still held");
`endif

endmodule
